// ===== rtl/core/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int OP_W     = 3;
  localparam int SLOT_W   = 11;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 8;   // bitmap bits per memory word
  localparam int WSEL_W   = 3;   // bit select inside one word
  localparam int SCAN_W   = SLOT_W - WSEL_W;

  typedef enum logic [OP_W-1:0] {
    OP_TEST  = 3'd0,
    OP_FIND  = 3'd1,
    OP_CLAIM = 3'd2,
    OP_SET   = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_USED      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WORK
  } state_t;

  // position of the lowest clear bit; only meaningful when one exists
  function automatic logic [WSEL_W-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [WSEL_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = WSEL_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/bsa_if.sv =====
// ----------------------------------------------------------------------------
// bsa request and response channels
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
interface bsa_req_if import bsa_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SLOT_W-1:0] slot_number;

  modport source (output valid, output operation, output slot_number, input ready);
  modport sink   (input valid, input operation, input slot_number, output ready);
endinterface

interface bsa_rsp_if import bsa_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                bit_value;
  logic [SLOT_W-1:0]   found_slot;
  logic [SLOT_W-1:0]   free_count;

  modport source (output valid, output status, output bit_value, output found_slot,
                  output free_count, input ready);
  modport sink   (input valid, input status, input bit_value, input found_slot,
                  input free_count, output ready);
endinterface

// ===== rtl/core/bsa_bitmap_ram.sv =====
// ----------------------------------------------------------------------------
// bsa_bitmap_ram
// Bitmap storage, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsa_bitmap_ram
  import bsa_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata_r
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer: clearing sweep, read-modify-write of one bitmap word, word scan
// for find-free, free count and the result register.
// ----------------------------------------------------------------------------
module bsa_ctrl
  import bsa_pkg::*;
#(
  parameter int                DEPTH      = 128,
  parameter int                AW         = 7,
  parameter logic [SLOT_W-1:0] FREE_RESET = 11'd1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] n_active,
  bsa_req_if.sink           in_req,
  bsa_rsp_if.source         out_rsp,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [WORD_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [WORD_W-1:0] mem_rdata
);

  state_t state_r, state_nxt;
  logic [AW-1:0]     clr_r;
  logic [OP_W-1:0]   op_r;
  logic [SLOT_W-1:0] idx_r;
  logic              in_range_r;
  logic [SLOT_W-1:0] n_r;
  logic [SCAN_W-1:0] words_r;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic [SLOT_W-1:0] free_r, free_nxt;

  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic              bit_r, bit_nxt;
  logic [SLOT_W-1:0] found_r, found_nxt;

  logic              accept;
  logic              in_range_in;
  logic [SLOT_W-1:0] idx_in;
  logic              done;
  logic              out_load;
  logic              scan_step;
  logic              old_bit;
  logic              hit;
  logic              last_word;
  logic              wb_en;
  logic [WORD_W-1:0] wb_word;
  logic [SCAN_W:0]   scan_inc;

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign idx_in       = in_req.slot_number - 11'd1;
  assign in_range_in  = (in_req.slot_number != '0) && (in_req.slot_number <= n_active);

  assign old_bit   = mem_rdata[idx_r[WSEL_W-1:0]];
  assign hit       = (words_r != '0) && (mem_rdata != '1);
  assign scan_inc  = {1'b0, scan_r} + 1'b1;
  assign last_word = scan_inc >= {1'b0, words_r};

  always_comb begin
    status_nxt = ST_OK;
    bit_nxt    = 1'b0;
    found_nxt  = '0;
    free_nxt   = free_r;
    done       = 1'b1;
    scan_step  = 1'b0;
    wb_en      = 1'b0;
    wb_word    = mem_rdata;
    case (op_r)
      OP_FIND: begin
        if (hit) begin
          found_nxt = {scan_r, first_zero(mem_rdata)} + 11'd1;
        end else begin
          status_nxt = ST_NOT_FOUND;
          done       = last_word;
          scan_step  = !last_word;
        end
      end
      OP_TEST: begin
        if (!in_range_r) begin
          status_nxt = ST_RANGE;
        end else begin
          bit_nxt = old_bit;
        end
      end
      OP_CLAIM: begin
        if (!in_range_r) begin
          status_nxt = ST_RANGE;
        end else if (old_bit) begin
          status_nxt = ST_USED;
        end else begin
          wb_en = 1'b1;
          wb_word[idx_r[WSEL_W-1:0]] = 1'b1;
          if (free_r != '0) begin
            free_nxt = free_r - 11'd1;
          end
        end
      end
      OP_SET: begin
        if (!in_range_r) begin
          status_nxt = ST_RANGE;
        end else begin
          wb_en = 1'b1;
          wb_word[idx_r[WSEL_W-1:0]] = 1'b1;
          if (free_r != '0) begin
            free_nxt = free_r - 11'd1;
          end
        end
      end
      OP_CLEAR: begin
        if (!in_range_r) begin
          status_nxt = ST_RANGE;
        end else begin
          wb_en = 1'b1;
          wb_word[idx_r[WSEL_W-1:0]] = 1'b0;
          if (free_r < n_r) begin
            free_nxt = free_r + 11'd1;
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign out_load = (state_r == S_WORK) && done && (!out_valid_r || out_rsp.ready);
  assign scan_nxt = scan_step ? scan_inc[SCAN_W-1:0] : scan_r;

  // memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(idx_r >> WSEL_W);
    mem_wdata = wb_word;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (out_load && wb_en) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (accept) begin
      mem_re = 1'b1;
      if (in_req.operation != OP_FIND && in_range_in) begin
        mem_raddr = AW'(idx_in >> WSEL_W);
      end
    end else if (state_r == S_WORK && scan_step) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(scan_inc);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_WORK;
        end
      end
      S_WORK: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_r      <= FREE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (out_load) begin
        free_r      <= free_nxt;
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_req.operation;
      idx_r      <= idx_in;
      in_range_r <= in_range_in;
      n_r        <= n_active;
      words_r    <= n_active[SLOT_W-1:WSEL_W];
      scan_r     <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
    if (out_load) begin
      status_r <= status_nxt;
      bit_r    <= bit_nxt;
      found_r  <= found_nxt;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = status_r;
  assign out_rsp.bit_value  = bit_r;
  assign out_rsp.found_slot = found_r;
  assign out_rsp.free_count = free_r;

  // bitmap is only written by the clearing sweep or a completing beat
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR) || out_load)
    else $error("bitmap write outside sweep or completion");

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || out_rsp.ready)
    else $error("result register overwritten");

  // free count moves only when a request completes
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(free_r))
    else $error("free count changed without a completing request");

  // a successful find returns a slot inside the active range
  a_find_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && op_r == OP_FIND && status_nxt == ST_OK)
      |-> (found_nxt != '0) && (found_nxt <= n_r))
    else $error("find returned a slot outside the active range");

endmodule

// ===== rtl/core/bitmap_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// Test, find-free, claim, force set and force clear over a slot bitmap.
// ----------------------------------------------------------------------------
// Test, claim, set and clear: the bitmap word is read as the request is taken; a
//   change is written back as the result loads; no new request is taken until the result is loaded.
// Find free: scans one 8-slot memory word per cycle from word 0 up to the first word
//   with a clear bit or the last active word; the single read port sets the pace.
// After reset the bitmap is swept to zero word by word, no requests taken;
//   slots_in_use resets to 1024 and the free count to the active slot count.
module bitmap_slot_allocator_top
  import bsa_pkg::*;
#(
  parameter int SLOTS = 1024   // multiple of eight
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SLOT_W-1:0] cfg_wr_data,
  bsa_req_if.sink           in_req,
  bsa_rsp_if.source         out_rsp
);

  localparam int DEPTH     = SLOTS / WORD_W;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOTS_CAP = (SLOTS > 2047) ? 2047 : SLOTS;
  localparam int RST_CAP   = (SLOTS_CAP < 1024) ? SLOTS_CAP : 1024;
  localparam logic [SLOT_W-1:0] CAP        = SLOT_W'(SLOTS_CAP);
  localparam logic [SLOT_W-1:0] FREE_RESET = SLOT_W'(RST_CAP - (RST_CAP % 8));
  localparam logic [SLOT_W-1:0] CFG_RESET  = 11'd1024;

  logic [SLOT_W-1:0] slots_in_use_r;
  logic [SLOT_W-1:0] n_active;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      slots_in_use_r <= cfg_wr_data;
    end
  end

  // capped at the storage size, rounded down to whole words
  assign n_active = ((slots_in_use_r < CAP) ? slots_in_use_r : CAP) & ~SLOT_W'(7);

  bsa_ctrl #(
    .DEPTH      (DEPTH),
    .AW         (AW),
    .FREE_RESET (FREE_RESET)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_active  (n_active),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  bsa_bitmap_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives allocator requests through the valid/ready channels and checks each
// result against a bitmap predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench
  import bsa_pkg::*;
;

  localparam int SLOTS = 1024;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    status_t           status;
    logic              bit_value;
    logic [SLOT_W-1:0] found_slot;
    logic [SLOT_W-1:0] free_count;
  } alloc_result_t;

  class alloc_scoreboard;
    bit                slot_map [SLOTS];   // entry 0 holds slot 1
    logic [SLOT_W-1:0] free_cnt;
    logic [SLOT_W-1:0] slots_reg;
    alloc_result_t     pending_results [$];
    int                mismatches;

    function new();
      foreach (slot_map[i]) slot_map[i] = 1'b0;
      slots_reg  = SLOT_W'(1024);
      free_cnt   = SLOT_W'(active_slots());
      mismatches = 0;
    endfunction

    // register clipped to the bitmap size, whole words only
    function int unsigned active_slots();
      int unsigned n;
      n = (slots_reg > SLOTS) ? SLOTS : slots_reg;
      return n - (n % 8);
    endfunction

    function void write_cfg(logic [SLOT_W-1:0] value);
      slots_reg = value;
    endfunction

    function logic [SLOT_W-1:0] lowest_free();
      int unsigned n;
      n = active_slots();
      for (int i = 0; i < n; i++) begin
        if (!slot_map[i]) return SLOT_W'(i + 1);
      end
      return '0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot);
      alloc_result_t r;
      int unsigned   n;
      int unsigned   idx;
      bit            hit;
      n   = active_slots();
      hit = (slot >= 1) && (slot <= n);
      idx = hit ? slot - 1 : 0;
      r   = '0;
      r.status = ST_OK;
      case (op)
        OP_FIND: begin
          r.found_slot = lowest_free();
          if (r.found_slot == '0) r.status = ST_NOT_FOUND;
        end
        OP_TEST, OP_CLAIM, OP_SET, OP_CLEAR: begin
          if (!hit) begin
            r.status = ST_RANGE;
          end else begin
            case (op)
              OP_TEST: r.bit_value = slot_map[idx];
              OP_CLAIM: begin
                if (slot_map[idx]) begin
                  r.status = ST_USED;
                end else begin
                  slot_map[idx] = 1'b1;
                  if (free_cnt > 0) free_cnt--;
                end
              end
              OP_SET: begin
                slot_map[idx] = 1'b1;
                if (free_cnt > 0) free_cnt--;
              end
              default: begin
                slot_map[idx] = 1'b0;
                if (free_cnt < n) free_cnt++;
              end
            endcase
          end
        end
        default: ;   // unused codes leave everything alone
      endcase
      r.free_count = free_cnt;
      pending_results.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      if (pending_results.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result beat: status %0d bit %0d found %0d free %0d",
                   got.status, got.bit_value, got.found_slot, got.free_count);
        end
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      if (got !== exp) begin
        if (mismatches < 10) begin
          $display("result mismatch: expected status %0d bit %0d found %0d free %0d",
                   exp.status, exp.bit_value, exp.found_slot, exp.free_count);
          $display("                 actual   status %0d bit %0d found %0d free %0d",
                   got.status, got.bit_value, got.found_slot, got.free_count);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [SLOT_W-1:0] cfg_wr_data;
  bit                steady = 1'b0;   // no idling on either side while set
  int unsigned       cycles = 0;
  alloc_result_t     seen_result;
  alloc_scoreboard   sb;

  bsa_req_if in_ch ();
  bsa_rsp_if out_ch ();

  bitmap_slot_allocator_top #(
    .SLOTS(SLOTS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_req     (in_ch),
    .out_rsp    (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_result.status     = status_t'(out_ch.status);
      seen_result.bit_value  = out_ch.bit_value;
      seen_result.found_slot = out_ch.found_slot;
      seen_result.free_count = out_ch.free_count;
      sb.check_result(seen_result);
    end
  end

  task automatic send_req(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot);
    while (!steady && $urandom_range(99) < 16) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.slot_number <= slot;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, slot);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slots(input logic [SLOT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_cfg(value);
  endtask

  // mostly inside the active range, some on its edges, some anywhere
  function automatic logic [SLOT_W-1:0] pick_slot(int unsigned n);
    int unsigned roll;
    roll = $urandom_range(99);
    if (n > 0 && roll < 70) return SLOT_W'($urandom_range(n, 1));
    if (roll < 85) begin
      case ($urandom_range(2))
        0:       return '0;
        1:       return SLOT_W'(n);
        default: return SLOT_W'(n + 1);
      endcase
    end
    return SLOT_W'($urandom_range(2047));
  endfunction

  task automatic random_item(input bit clear_heavy);
    int unsigned       roll;
    int unsigned       n;
    logic [SLOT_W-1:0] target;
    if ($urandom_range(99) == 0) wait_drained();
    n    = sb.active_slots();
    roll = $urandom_range(99);
    if (roll < 12) begin
      // usual allocator pattern: look up the lowest free slot, then claim it
      target = sb.lowest_free();
      send_req(OP_FIND, pick_slot(n));
      send_req(OP_CLAIM, target);
    end else if (roll < 17) begin
      send_req(OP_W'($urandom_range(7, 5)), SLOT_W'($urandom_range(2047)));
    end else if (roll < 32) begin
      send_req(OP_TEST, pick_slot(n));
    end else if (roll < 42) begin
      send_req(OP_FIND, pick_slot(n));
    end else if (roll < 57) begin
      send_req(OP_CLAIM, pick_slot(n));
    end else if (roll < (clear_heavy ? 67 : 80)) begin
      send_req(OP_SET, pick_slot(n));
    end else begin
      send_req(OP_CLEAR, pick_slot(n));
    end
  endtask

  task automatic run_phase(input logic [SLOT_W-1:0] cfg_val, input int items,
                           input bit clear_heavy);
    wait_drained();
    write_slots(cfg_val);
    repeat (items) random_item(clear_heavy);
  endtask

  // fill the whole bitmap in order so find-free scans deeper and deeper,
  // and run the free count down to zero
  task automatic fill_phase();
    int unsigned next_slot;
    int unsigned extra;
    int unsigned k;
    bit          at_zero;
    wait_drained();
    write_slots(SLOT_W'(2047));
    next_slot = 1;
    extra     = 0;
    k         = 0;
    at_zero   = 1'b0;
    while (extra < 40) begin
      steady = (k >= 300 && k < 650);
      if (!at_zero && $urandom_range(99) < 92) begin
        send_req(OP_SET, (next_slot <= SLOTS) ? SLOT_W'(next_slot)
                                              : SLOT_W'($urandom_range(SLOTS, 1)));
        next_slot++;
      end else begin
        random_item(1'b0);
      end
      if (sb.free_cnt == 0 && next_slot > SLOTS) at_zero = 1'b1;
      if (at_zero) extra++;
      k++;
    end
    steady = 1'b0;
  endtask

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= '0;
    in_ch.slot_number <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: range edges, every operation, saturation at the top
    send_req(OP_TEST, SLOT_W'(1));
    send_req(OP_TEST, SLOT_W'(0));
    send_req(OP_TEST, SLOT_W'(1024));
    send_req(OP_TEST, SLOT_W'(1025));
    send_req(OP_TEST, SLOT_W'(2047));
    send_req(OP_FIND, SLOT_W'(0));
    send_req(OP_CLEAR, SLOT_W'(1));
    send_req(OP_CLAIM, SLOT_W'(1));
    send_req(OP_CLAIM, SLOT_W'(1));
    send_req(OP_FIND, SLOT_W'(2047));
    send_req(OP_SET, SLOT_W'(1024));
    send_req(OP_SET, SLOT_W'(1024));
    send_req(OP_TEST, SLOT_W'(1024));
    send_req(OP_CLEAR, SLOT_W'(1024));
    send_req(OP_CLEAR, SLOT_W'(1024));
    send_req(OP_CLAIM, SLOT_W'(0));
    send_req(OP_SET, SLOT_W'(2047));
    send_req(OP_CLEAR, SLOT_W'(1025));
    send_req(OP_W'(5), SLOT_W'(1));
    send_req(OP_W'(6), SLOT_W'(2047));
    send_req(OP_W'(7), SLOT_W'(0));
    send_req(OP_FIND, SLOT_W'(5));
    send_req(OP_CLAIM, SLOT_W'(1024));

    // small range with the count far above it, then the long fill
    run_phase(SLOT_W'(16), 30, 1'b0);
    fill_phase();
    run_phase(SLOT_W'(0), 12, 1'b0);
    run_phase(SLOT_W'(7), 10, 1'b0);
    run_phase(SLOT_W'(1023), 15, 1'b1);
    run_phase(SLOT_W'(8), 12, 1'b1);
    run_phase(SLOT_W'($urandom_range(2047)), 12, 1'b0);
    run_phase(SLOT_W'(1024), 12, 1'b1);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
